// ===== design/sed_pkg.sv =====
// Package for the string escape decoder: decode modes, status codes and the
// result record. Used by sed_decode, string_escape_decoder and sed_checker.
package sed_pkg;

  // Decoder mode between input beats.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_OCT2   = 3'd4,
    MODE_OCT3   = 3'd5,
    MODE_ERROR  = 3'd6
  } mode_t;

  // Status codes carried on every result beat.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_BADHEX  = 3'd2;
  localparam logic [2:0] ST_BADOCT  = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  // Substitute for a decoded value of zero.
  localparam logic [7:0] ZERO_SUBST = 8'hff;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       string_done;
  } sed_result_t;

endpackage

// ===== design/string_escape_decoder.sv =====
// String escape decoder: each input beat passes through the input register,
// then is decoded into the result register.
// Throughput one beat per cycle while the output is not stalled.
// Synchronous active-high reset empties both stages and returns the
// decoder to normal mode with no collected digits.
// Top level: input stage and handshake control. Depends on sed_pkg, sed_decode.
module string_escape_decoder import sed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       byte_valid,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       string_done
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;
  logic        advance;
  sed_result_t result;

  // The held beat moves on when the result register is free or drains now.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
      hold_last <= end_of_string;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  sed_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .in_byte       (hold_byte),
    .end_of_string (hold_last),
    .result        (result)
  );

  assign byte_valid  = result.byte_valid;
  assign out_byte    = result.out_byte;
  assign status      = result.status;
  assign string_done = result.string_done;

endmodule

// ===== design/sed_decode.sv =====
// Decode step of the string escape decoder: mode state machine plus the
// result register. Depends on sed_pkg.
module sed_decode import sed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output sed_result_t result
);

  mode_t       mode, mode_next;
  logic [7:0]  partial_value, partial_next;
  sed_result_t result_next;

  logic       hex_ok, oct_ok, simple_ok;
  logic [3:0] hex_val;
  logic [2:0] oct_val;
  logic [7:0] simple_val;
  logic [7:0] val;
  logic       valid;

  // Hex and octal digit recognition.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte inside {["0":"9"]}) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte inside {["a":"f"]}) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte inside {["A":"F"]}) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
    oct_ok  = in_byte inside {["0":"7"]};
    oct_val = in_byte[2:0];
  end

  // Single-character escapes.
  always_comb begin
    simple_ok = 1'b1;
    case (in_byte)
      "a", "g": simple_val = 8'd7;
      "b":      simple_val = 8'd8;
      "c":      simple_val = 8'h9b;
      "e":      simple_val = 8'd27;
      "f":      simple_val = 8'd12;
      "n":      simple_val = 8'd10;
      "r":      simple_val = 8'd13;
      "t":      simple_val = 8'd9;
      "v":      simple_val = 8'd11;
      "\\":     simple_val = 8'h5c;
      "\"":     simple_val = 8'h22;
      default: begin
        simple_ok  = 1'b0;
        simple_val = 8'd0;
      end
    endcase
  end

  // Next mode, collected digits and the result for this beat.
  always_comb begin
    mode_next    = mode;
    partial_next = partial_value;
    valid        = 1'b0;
    val          = 8'd0;
    result_next  = '0;
    case (mode)
      MODE_ESC: begin
        if (in_byte == "x") begin
          mode_next = MODE_HEX1;
        end else if (in_byte inside {["0":"3"]}) begin
          partial_next = {6'd0, in_byte[1:0]};
          mode_next    = MODE_OCT2;
        end else if (simple_ok) begin
          valid     = 1'b1;
          val       = simple_val;
          mode_next = MODE_NORMAL;
        end else begin
          result_next.status = ST_UNKNOWN;
          mode_next          = MODE_ERROR;
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (!hex_ok) begin
          result_next.status = ST_BADHEX;
          mode_next          = MODE_ERROR;
        end else if (mode == MODE_HEX1) begin
          partial_next = {4'd0, hex_val};
          mode_next    = MODE_HEX2;
        end else begin
          valid     = 1'b1;
          val       = {partial_value[3:0], hex_val};
          mode_next = MODE_NORMAL;
        end
      end
      MODE_OCT2, MODE_OCT3: begin
        if (!oct_ok) begin
          result_next.status = ST_BADOCT;
          mode_next          = MODE_ERROR;
        end else if (mode == MODE_OCT2) begin
          partial_next = {partial_value[4:0], oct_val};
          mode_next    = MODE_OCT3;
        end else begin
          valid     = 1'b1;
          val       = {partial_value[4:0], oct_val};
          mode_next = MODE_NORMAL;
        end
      end
      MODE_ERROR: begin
        mode_next = MODE_ERROR;
      end
      default: begin
        if (in_byte == "\\") begin
          mode_next = MODE_ESC;
        end else begin
          valid     = 1'b1;
          val       = in_byte;
          mode_next = MODE_NORMAL;
        end
      end
    endcase

    if (valid && val == 8'd0) begin
      val = ZERO_SUBST;
    end

    // The string end closes any open escape and returns to normal mode.
    if (end_of_string) begin
      if (mode_next inside {[MODE_ESC:MODE_OCT3]}) begin
        result_next.status = ST_TRUNC;
      end
      mode_next    = MODE_NORMAL;
      partial_next = 8'd0;
    end

    result_next.byte_valid  = valid;
    result_next.out_byte    = valid ? val : 8'd0;
    result_next.string_done = end_of_string;
  end

  // State and result register advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      partial_value <= 8'd0;
    end else if (step) begin
      mode          <= mode_next;
      partial_value <= partial_next;
    end
    if (step) begin
      result <= result_next;
    end
  end

endmodule

// ===== design/sed_checker.sv =====
// Port-level checks for the string escape decoder, bound to the top level.
// Depends on sed_pkg.
module sed_checker import sed_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       end_of_string,
  input logic       out_valid,
  input logic       out_stall,
  input logic       byte_valid,
  input logic [7:0] out_byte,
  input logic [2:0] status,
  input logic       string_done
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_valid) && $stable(out_byte)
      && $stable(status) && $stable(string_done))
    else $error("result beat changed while stalled");

  // A delivered byte is never zero; no byte means a zero field.
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> out_byte != 8'd0)
    else $error("decoded byte of zero was delivered");

  a_byte_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("out_byte nonzero without byte_valid");

  // An error or truncation report never carries a byte, and its code is in range.
  a_err_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !byte_valid && status <= ST_TRUNC)
    else $error("error status with a byte or out of range");

  // Truncation is only reported on the last beat of a string.
  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TRUNC |-> string_done)
    else $error("truncation reported before string end");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);

// ===== dv/tb_string_escape_decoder.sv =====
// Self-checking testbench for the string escape decoder: queued character beats drive
// the input, and an in-bench decoder predicts each result beat for the output check.
// Depends on sed_pkg and string_escape_decoder.
module tb_string_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import sed_pkg::*;

  localparam int RANDOM_CHARS = 2000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_EVERY   = 400;

  // One character beat waiting to be sent; hold makes the sender wait for all results.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         hold;
  } char_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h20;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       string_done;

  char_beat_t  char_q[$];
  sed_result_t decoded_q[$];

  // Decoder state as seen by the prediction.
  mode_t      esc_mode = MODE_NORMAL;
  logic [7:0] digit_acc = '0;
  bit         failed = 1'b0;

  string_escape_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .end_of_string(end_of_string),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_valid(byte_valid),
    .out_byte(out_byte),
    .status(status),
    .string_done(string_done)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, now and then a long pause.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Decodes one source character and advances the predicted decoder state.
  function automatic sed_result_t decode_char(input logic [7:0] c, input logic last);
    sed_result_t r;
    logic [7:0]  val;
    logic [4:0]  dig;
    r = '0;
    val = '0;
    r.status = ST_OK;
    case (esc_mode)
      MODE_ESC: begin
        if (c == "x") begin
          esc_mode = MODE_HEX1;
        end else if (c >= "0" && c <= "3") begin
          digit_acc = c - "0";
          esc_mode = MODE_OCT2;
        end else begin
          r.byte_valid = 1'b1;
          esc_mode = MODE_NORMAL;
          case (c)
            "a", "g": val = 8'd7;
            "b":      val = 8'd8;
            "c":      val = 8'h9b;
            "e":      val = 8'd27;
            "f":      val = 8'd12;
            "n":      val = 8'd10;
            "r":      val = 8'd13;
            "t":      val = 8'd9;
            "v":      val = 8'd11;
            "\\":     val = "\\";
            "\"":     val = "\"";
            default: begin
              r.byte_valid = 1'b0;
              r.status = ST_UNKNOWN;
              esc_mode = MODE_ERROR;
            end
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (c >= "0" && c <= "9") dig = 5'(c - "0");
        else if (c >= "a" && c <= "f") dig = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") dig = 5'(c - "A" + 8'd10);
        else dig = 5'd16;
        if (dig[4]) begin
          r.status = ST_BADHEX;
          esc_mode = MODE_ERROR;
        end else if (esc_mode == MODE_HEX1) begin
          digit_acc = {4'd0, dig[3:0]};
          esc_mode = MODE_HEX2;
        end else begin
          r.byte_valid = 1'b1;
          val = {digit_acc[3:0], dig[3:0]};
          esc_mode = MODE_NORMAL;
        end
      end
      MODE_OCT2, MODE_OCT3: begin
        if (c >= "0" && c <= "7") begin
          dig = 5'(c - "0");
          if (esc_mode == MODE_OCT2) begin
            digit_acc = {digit_acc[4:0], dig[2:0]};
            esc_mode = MODE_OCT3;
          end else begin
            r.byte_valid = 1'b1;
            val = {digit_acc[4:0], dig[2:0]};
            esc_mode = MODE_NORMAL;
          end
        end else begin
          r.status = ST_BADOCT;
          esc_mode = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
      end
      default: begin
        if (c == "\\") begin
          esc_mode = MODE_ESC;
        end else begin
          r.byte_valid = 1'b1;
          val = c;
          esc_mode = MODE_NORMAL;
        end
      end
    endcase

    // A decoded zero goes out as the substitute value.
    if (r.byte_valid && val == 8'd0) val = ZERO_SUBST;

    // String end: an unfinished escape is reported, and the state starts over.
    if (last) begin
      if (esc_mode >= MODE_ESC && esc_mode <= MODE_OCT3) r.status = ST_TRUNC;
      esc_mode = MODE_NORMAL;
      digit_acc = '0;
    end

    r.out_byte = r.byte_valid ? val : 8'd0;
    r.string_done = last;
    return r;
  endfunction

  task automatic push_text(input string s, input bit hold);
    for (int i = 0; i < s.len(); i++) begin
      char_q.push_back('{s[i], (i == s.len() - 1), (hold && i == 0)});
    end
  endtask

  // Builds one random string of plain characters and escapes, mostly well-formed.
  task automatic push_random_string(input bit hold, output int n_chars);
    string      esc_chars;
    logic [7:0] text[$];
    logic [7:0] c;
    int         n_tokens;
    int         r;
    int         v;
    esc_chars = "agbcefnrtv\\\"";
    n_tokens = $urandom_range(1, 6);
    for (int t = 0; t < n_tokens; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        c = 8'($urandom_range(1, 255));
        text.push_back(c == "\\" ? 8'h5b : c);
      end else if (r < 60) begin
        text.push_back("\\");
        text.push_back(esc_chars[$urandom_range(0, esc_chars.len() - 1)]);
      end else if (r < 72) begin
        text.push_back("\\");
        text.push_back("x");
        repeat (2) begin
          v = $urandom_range(0, 15);
          if (v < 10) text.push_back(8'("0" + v));
          else if ($urandom_range(0, 1)) text.push_back(8'("a" + v - 10));
          else text.push_back(8'("A" + v - 10));
        end
      end else if (r < 84) begin
        text.push_back("\\");
        text.push_back(8'("0" + $urandom_range(0, 3)));
        text.push_back(8'("0" + $urandom_range(0, 7)));
        text.push_back(8'("0" + $urandom_range(0, 7)));
      end else if (r < 92) begin
        // Escape with any character after it: mostly unknown escapes.
        text.push_back("\\");
        text.push_back(8'($urandom_range(1, 255)));
      end else begin
        // Numeric escape with a random, often invalid, digit.
        text.push_back("\\");
        text.push_back($urandom_range(0, 1) ? "x" : 8'("0" + $urandom_range(0, 3)));
        text.push_back(8'($urandom_range(1, 255)));
      end
    end
    // Some strings are cut short, often in the middle of an escape.
    if (text.size() > 1 && $urandom_range(0, 9) == 0) begin
      text = text[0:$urandom_range(0, text.size() - 2)];
    end
    foreach (text[i]) begin
      char_q.push_back('{text[i], (i == text.size() - 1), (hold && i == 0)});
    end
    n_chars = text.size();
  endtask

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
    failed = 1'b1;
  endtask

  // Sender: offers queued beats with random gaps and predicts each accepted beat.
  int tx_gap = 0;
  int tx_phase_left = 0;
  bit tx_quiet = 1'b0;

  always @(posedge clk) begin : drive_chars
    logic       nxt_valid;
    char_beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
      esc_mode = MODE_NORMAL;
      digit_acc = '0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        decoded_q.push_back(decode_char(in_byte, end_of_string));
        nxt_valid = 1'b0;
        if (tx_phase_left == 0) begin
          tx_phase_left = $urandom_range(50, 400);
          tx_quiet = ($urandom_range(0, 3) == 0);
        end
        tx_phase_left--;
        tx_gap = tx_quiet ? 0 : idle_gap();
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (char_q.size() != 0 && !(char_q[0].hold && decoded_q.size() != 0)) begin
          b = char_q.pop_front();
          in_byte <= b.ch;
          end_of_string <= b.last;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: random stall pattern, and each accepted result beat checked in order.
  int rx_stall_left = 0;
  int rx_phase_left = 0;
  bit rx_quiet = 1'b0;

  always @(posedge clk) begin : check_results
    sed_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result beat, valid %b byte %h status %0d done %b",
                   $time, byte_valid, out_byte, status, string_done);
          failed = 1'b1;
        end else begin
          want = decoded_q.pop_front();
          if (byte_valid !== want.byte_valid)
            report_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
          if (out_byte !== want.out_byte)
            report_field("out_byte", want.out_byte, out_byte);
          if (status !== want.status)
            report_field("status", 8'(want.status), 8'(status));
          if (string_done !== want.string_done)
            report_field("string_done", 8'(want.string_done), 8'(string_done));
        end
      end

      if (rx_phase_left == 0) begin
        rx_phase_left = $urandom_range(100, 500);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      rx_phase_left--;
      if (rx_stall_left > 0) begin
        out_stall <= 1'b1;
        rx_stall_left--;
      end else begin
        out_stall <= 1'b0;
        rx_stall_left = rx_quiet ? 0 : idle_gap();
      end
    end
  end

  // Watchdog on cycles where neither side moves a beat.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    int sent;
    int n;
    // Byte extremes as plain characters.
    char_q.push_back('{8'h01, 1'b0, 1'b0});
    char_q.push_back('{8'hff, 1'b1, 1'b0});
    // Hex zero turns into the substitute; largest octal code.
    push_text("\\x00", 1'b0);
    push_text("\\377", 1'b0);
    // Unknown escape, then a suppressed character.
    push_text("\\qz", 1'b0);
    // Bad digits on the last character report the digit error.
    push_text("\\xg", 1'b0);
    push_text("\\08", 1'b0);
    // Strings that end inside an escape.
    push_text("\\x4", 1'b0);
    push_text("\\", 1'b0);

    sent = 0;
    while (sent < RANDOM_CHARS) begin
      push_random_string((sent % HOLD_EVERY) < 6, n);
      sent += n;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (char_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (!failed && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sed_pkg.sv
design/sed_decode.sv
design/string_escape_decoder.sv
design/sed_checker.sv
dv/tb_string_escape_decoder.sv
